@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

@@ sv/lzmc_pkg.sv @@
// Types and constants for the LZ match copy engine
`timescale 1ns / 1ps
package lzmc_pkg;

  localparam int BYTE_W            = 8;
  localparam int DIST_W            = 12;
  localparam int LEN_W             = 7;
  localparam int DEF_WINDOW_BYTES  = 4096;
  localparam int DEF_MAX_MATCH_LEN = 64;
  localparam int CMD_Q_DEPTH       = 4;

  localparam logic OP_LIT  = 1'b0;
  localparam logic OP_COPY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_ERR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [BYTE_W-1:0]   lit;
    logic [DIST_W-1:0]   distance;
    logic [LEN_W-1:0]    len;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_COPY
  } back_state_e;

  typedef struct packed {
    logic data_vld;
    logic busy;
  } back_status_t;

endpackage

@@ sv/lzmc_front.sv @@
// Front end: accepts items, checks distance against the fill count, queues commands
`timescale 1ns / 1ps
module lzmc_front import lzmc_pkg::*; #(
  parameter int WINDOW_BYTES  = DEF_WINDOW_BYTES,
  parameter int MAX_MATCH_LEN = DEF_MAX_MATCH_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] literal_byte_i,
  input  logic [DIST_W-1:0] distance_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  localparam int FW = $clog2(WINDOW_BYTES + 1);
  localparam int CW = ((FW > DIST_W) ? FW : DIST_W) + 1;

  logic [FW-1:0]    filled_q, filled_d;
  logic             accept;
  logic             dist_bad;
  logic [LEN_W-1:0] len_sat;
  logic [CW-1:0]    add_amt;
  logic [CW-1:0]    fill_sum;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    len_sat = (length_i > LEN_W'(MAX_MATCH_LEN)) ? LEN_W'(MAX_MATCH_LEN) : length_i;
    dist_bad = (distance_i == '0) || (CW'(distance_i) > CW'(filled_q));

    if (op_i == OP_LIT) begin
      add_amt = CW'(1);
    end else if (dist_bad) begin
      add_amt = '0;
    end else begin
      add_amt = CW'(len_sat);
    end
    fill_sum = CW'(filled_q) + add_amt;
    filled_d = (fill_sum >= CW'(WINDOW_BYTES)) ? FW'(WINDOW_BYTES) : fill_sum[FW-1:0];

    q_cmd_o.lit      = literal_byte_i;
    q_cmd_o.distance = distance_i;
    q_cmd_o.len      = len_sat;
    if (op_i == OP_LIT) begin
      q_cmd_o.kind = CMD_LIT;
    end else if (dist_bad) begin
      q_cmd_o.kind = CMD_ERR;
    end else begin
      q_cmd_o.kind = CMD_COPY;
    end

    // drop a valid copy of zero length: it yields nothing
    q_push_o = accept && !((op_i == OP_COPY) && !dist_bad && (len_sat == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (accept) begin
      filled_q <= filled_d;
    end
  end

endmodule

@@ sv/lzmc_cmd_queue.sv @@
// Short command queue between the front end and the copy engine
`timescale 1ns / 1ps
module lzmc_cmd_queue import lzmc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = $clog2(CMD_Q_DEPTH);
  localparam int NW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t          slot_q [CMD_Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == NW'(CMD_Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ((wr_ptr_q == PW'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1)
                       : wr_ptr_q;
    rd_ptr_d = do_pop ? ((rd_ptr_q == PW'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1)
                      : rd_ptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ sv/lzmc_back.sv @@
// Copy engine: history memory, byte issue, read stage and output register
`timescale 1ns / 1ps
module lzmc_back import lzmc_pkg::*; #(
  parameter int WINDOW_BYTES = DEF_WINDOW_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  cmd_t              q_cmd_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] data_byte_o,
  output logic              last_o,
  output logic              error_o,
  output back_status_t      status_o
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int SW = ((AW > DIST_W) ? AW : DIST_W) + 1;

  logic [BYTE_W-1:0] hist_mem [WINDOW_BYTES];

  back_state_e       state_q, state_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [DIST_W-1:0] dist_q;
  logic [AW-1:0]     iwp_q;

  // issue controls
  logic              can_issue;
  logic              issue;
  cmd_kind_e         issue_kind;
  logic              issue_last;
  logic [DIST_W-1:0] dist_sel;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  // read stage
  logic              d_vld_q;
  cmd_kind_e         d_kind_q;
  logic [BYTE_W-1:0] d_lit_q;
  logic              d_last_q;
  logic              d_prev_q;
  logic [AW-1:0]     d_waddr_q;
  logic [BYTE_W-1:0] rdata_q;
  logic [BYTE_W-1:0] last_byte_q;
  logic [BYTE_W-1:0] d_byte;
  logic              d_move;
  logic              mem_we;

  // output register
  logic              out_vld_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_err_q;

  assign d_move    = d_vld_q && (!out_vld_q || !out_stall_i);
  assign can_issue = !d_vld_q || d_move;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && can_issue && (q_cmd_i.kind == CMD_COPY)
            && (q_cmd_i.len != LEN_W'(1))) begin
          state_d = BK_COPY;
        end
      end
      BK_COPY: begin
        if (can_issue && (cnt_q == LEN_W'(1))) begin
          state_d = BK_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    issue      = 1'b0;
    issue_kind = CMD_COPY;
    issue_last = 1'b0;
    dist_sel   = dist_q;
    cnt_d      = cnt_q;
    unique case (state_q)
      BK_IDLE: begin
        dist_sel = q_cmd_i.distance;
        if (!q_empty_i && can_issue) begin
          q_pop_o    = 1'b1;
          issue      = 1'b1;
          issue_kind = q_cmd_i.kind;
          issue_last = (q_cmd_i.kind != CMD_COPY) || (q_cmd_i.len == LEN_W'(1));
          cnt_d      = q_cmd_i.len - 1'b1;
        end
      end
      BK_COPY: begin
        if (can_issue) begin
          issue      = 1'b1;
          issue_last = (cnt_q == LEN_W'(1));
          cnt_d      = cnt_q - 1'b1;
        end
      end
    endcase
    rd_en = issue && (issue_kind == CMD_COPY);
  end

  // source address of the byte being issued: its own write slot minus distance
  always_comb begin
    if (SW'(iwp_q) >= SW'(dist_sel)) begin
      rd_addr = AW'(SW'(iwp_q) - SW'(dist_sel));
    end else begin
      rd_addr = AW'(SW'(iwp_q) + SW'(WINDOW_BYTES) - SW'(dist_sel));
    end
  end

  // distance one repeats the byte committed just before, which may be in flight
  always_comb begin
    unique case (d_kind_q)
      CMD_LIT:  d_byte = d_lit_q;
      CMD_COPY: d_byte = d_prev_q ? last_byte_q : rdata_q;
      CMD_ERR:  d_byte = '0;
      default:  d_byte = '0;
    endcase
    mem_we = d_move && (d_kind_q != CMD_ERR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cnt_q     <= '0;
      iwp_q     <= '0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (issue && (issue_kind != CMD_ERR)) begin
        iwp_q <= (iwp_q == AW'(WINDOW_BYTES - 1)) ? '0 : iwp_q + 1'b1;
      end
      if (issue) begin
        d_vld_q <= 1'b1;
      end else if (d_move) begin
        d_vld_q <= 1'b0;
      end
      if (d_move) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dist_q <= q_cmd_i.distance;
    end
    if (issue) begin
      d_kind_q  <= issue_kind;
      d_lit_q   <= q_cmd_i.lit;
      d_last_q  <= issue_last;
      d_prev_q  <= (dist_sel == DIST_W'(1));
      d_waddr_q <= iwp_q;
    end
    if (mem_we) begin
      last_byte_q <= d_byte;
    end
    if (d_move) begin
      out_byte_q <= d_byte;
      out_last_q <= d_last_q;
      out_err_q  <= (d_kind_q == CMD_ERR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[d_waddr_q] <= d_byte;
    end
    if (rd_en) begin
      rdata_q <= hist_mem[rd_addr];
    end
  end

  assign out_valid_o       = out_vld_q;
  assign data_byte_o       = out_byte_q;
  assign last_o            = out_last_q;
  assign error_o           = out_err_q;
  assign status_o.data_vld = d_vld_q;
  assign status_o.busy     = (state_q != BK_IDLE);

endmodule

@@ sv/lz_overlapping_match_copy_top.sv @@
// The first result of an item passes through the command queue, read stage and output register.
// Throughput: one result per cycle while the output is not stalled; literal and error items give
// one result each, a copy one per byte; the history memory has one write port and one read port.
// Up to four items queue ahead of the copy engine; input is taken while the queue has room.
// Reset clears the queue, pointers, fill count and output valid; history memory is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lz_overlapping_match_copy_top import lzmc_pkg::*; #(
  parameter int WINDOW_BYTES  = DEF_WINDOW_BYTES,
  parameter int MAX_MATCH_LEN = DEF_MAX_MATCH_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] literal_byte_i,
  input  logic [DIST_W-1:0] distance_i,
  input  logic [LEN_W-1:0]  length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] data_byte_o,
  output logic              last_o,
  output logic              error_o
);

  logic         q_push, q_pop, q_full, q_empty;
  cmd_t         q_wr_cmd, q_rd_cmd;
  back_status_t bk_status;

  lzmc_front #(
    .WINDOW_BYTES  (WINDOW_BYTES),
    .MAX_MATCH_LEN (MAX_MATCH_LEN)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .literal_byte_i (literal_byte_i),
    .distance_i     (distance_i),
    .length_i       (length_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (q_wr_cmd)
  );

  lzmc_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wr_cmd),
    .pop_i   (q_pop),
    .cmd_o   (q_rd_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lzmc_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_rd_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .error_o     (error_o),
    .status_o    (bk_status)
  );

  // an error item is a single marked result with a zero byte
  `ASSERT_IMPLIES(a_err_single, clk_i, rst_ni, out_valid_o && error_o, last_o && (data_byte_o == '0))

  // an accepted literal is queued before the engine can take it
  `ASSERT_NEXT(a_lit_queued, clk_i, rst_ni, in_valid_i && !in_stall_o && (op_i == OP_LIT), !q_empty)

  // a byte in the read stage is kept while the output register is held
  `ASSERT_NEXT(a_read_held, clk_i, rst_ni, bk_status.data_vld && out_valid_o && out_stall_i, bk_status.data_vld)

endmodule
